// ----- hw/rtl/hndq_pkg.sv -----
// ----------------------------------------------------------------------------
// hndq_pkg
// Shared types and constants of the humanized note delay queue.
// ----------------------------------------------------------------------------
package hndq_pkg;

    // item kinds
    localparam logic [1:0] K_SCHED  = 2'd0;
    localparam logic [1:0] K_ADV    = 2'd1;
    localparam logic [1:0] K_CANCEL = 2'd2;

    // configuration register indexes
    localparam logic CFG_VEL_SPREAD  = 1'b0;
    localparam logic CFG_TIME_SPREAD = 1'b1;

    localparam int RAND_W   = 32;
    localparam int CNT_W    = 6;
    localparam int QDEPTH   = 2;
    localparam logic [6:0] VEL_MAX = 7'd127;

    typedef struct packed {
        logic [6:0] note;
        logic [6:0] vel;
        logic [5:0] col;
        logic [7:0] smp;
    } t_note;

    typedef struct packed {
        logic [1:0]  kind;
        logic        park;
        t_note       ev;
        logic [15:0] delay;
        logic [15:0] frames;
    } t_cmd;

endpackage

// ----- hw/rtl/humanized_note_delay_queue_core.sv -----
// ----------------------------------------------------------------------------
// humanized_note_delay_queue_core
// Delayed note table with velocity and timing jitter.
// ----------------------------------------------------------------------------
// Usage: items enter on the in channel (valid/ready), fired notes leave on
// the out channel (valid/ready), one beat per note, last_of_run set on the
// final note of an item. Config registers are written on the cfg channel,
// always ready; the user must write them only while the block is idle, the block does not enforce this.
// A schedule item runs through two 32-step remainder units, side by side, in
// the front, then goes on to the back. Advance walks the slot table one slot
// a cycle while the out channel takes its notes. Cancel clears the slots of
// the item's column. The front takes the next item while the back still
// works, through a two-entry command queue. A stalled receiver holds the
// back on the next firing slot; the front keeps filling the queue until it
// is full.
// Reset clears the slot table valid bits, the queue and both registers.
// ----------------------------------------------------------------------------
module humanized_note_delay_queue_core #(
    parameter int PENDING_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [6:0]  i_note_number,
    input  logic [6:0]  i_note_velocity,
    input  logic [5:0]  i_column_id,
    input  logic [7:0]  i_sample_slot,
    input  logic [15:0] i_row_samples,
    input  logic [15:0] i_frame_count,
    input  logic [31:0] i_random_velocity,
    input  logic [31:0] i_random_delay,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_fired_note,
    output logic [6:0]  o_fired_velocity,
    output logic [5:0]  o_fired_column,
    output logic [7:0]  o_fired_sample,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    import hndq_pkg::*;

    logic [6:0] r_vel_spread;
    logic [9:0] r_time_spread;
    logic       w_push;
    logic       w_full;
    logic       w_pop;
    logic       w_qv;
    t_cmd       w_fcmd;
    t_cmd       w_bcmd;
    t_note      w_ev;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_spread  <= '0;
            r_time_spread <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VEL_SPREAD:  r_vel_spread  <= i_cfg_data[6:0];
                CFG_TIME_SPREAD: r_time_spread <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hndq_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_note_number     (i_note_number),
        .i_note_velocity   (i_note_velocity),
        .i_column_id       (i_column_id),
        .i_sample_slot     (i_sample_slot),
        .i_row_samples     (i_row_samples),
        .i_frame_count     (i_frame_count),
        .i_random_velocity (i_random_velocity),
        .i_random_delay    (i_random_delay),
        .i_vel_spread      (r_vel_spread),
        .i_time_spread     (r_time_spread),
        .i_q_full          (w_full),
        .o_q_push          (w_push),
        .o_q_cmd           (w_fcmd)
    );

    hndq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_fcmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qv),
        .o_cmd   (w_bcmd)
    );

    hndq_back #(.N(PENDING_SLOTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_qv),
        .i_q_cmd     (w_bcmd),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ev        (w_ev),
        .o_last      (o_last_of_run)
    );

    assign o_fired_note     = w_ev.note;
    assign o_fired_velocity = w_ev.vel;
    assign o_fired_column   = w_ev.col;
    assign o_fired_sample   = w_ev.smp;

endmodule

// ----- hw/rtl/hndq_urem.sv -----
// ----------------------------------------------------------------------------
// hndq_urem
// Restoring remainder unit: 32-bit dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hndq_urem #(
    parameter int DW = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [hndq_pkg::RAND_W-1:0]     i_dividend,
    input  logic [DW-1:0]                   i_divisor,
    output logic                            o_busy,
    output logic [DW-1:0]                   o_rem
);
    import hndq_pkg::*;

    logic [CNT_W-1:0]  r_cnt;
    logic [RAND_W-1:0] r_dvd;
    logic [DW-1:0]     r_rem;
    logic [DW:0]       w_sh;
    logic [DW:0]       w_diff;

    assign w_sh   = {r_rem, r_dvd[RAND_W-1]};
    assign w_diff = w_sh - {1'b0, i_divisor};
    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(RAND_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (o_busy) begin
            r_dvd <= r_dvd << 1;
            if (w_sh >= {1'b0, i_divisor}) begin
                r_rem <= w_diff[DW-1:0];
            end else begin
                r_rem <= w_sh[DW-1:0];
            end
        end
    end

endmodule

// ----- hw/rtl/hndq_front.sv -----
// ----------------------------------------------------------------------------
// hndq_front
// Accepts items, applies velocity and delay jitter, queues commands.
// ----------------------------------------------------------------------------
module hndq_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_kind,
    input  logic [6:0]           i_note_number,
    input  logic [6:0]           i_note_velocity,
    input  logic [5:0]           i_column_id,
    input  logic [7:0]           i_sample_slot,
    input  logic [15:0]          i_row_samples,
    input  logic [15:0]          i_frame_count,
    input  logic [31:0]          i_random_velocity,
    input  logic [31:0]          i_random_delay,
    input  logic [6:0]           i_vel_spread,
    input  logic [9:0]           i_time_spread,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output hndq_pkg::t_cmd       o_q_cmd
);
    import hndq_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CALC = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]  r_state;
    logic [1:0]  n_state;
    logic [1:0]  r_kind;
    logic [6:0]  r_note;
    logic [6:0]  r_vel;
    logic [5:0]  r_col;
    logic [7:0]  r_smp;
    logic [15:0] r_row;
    logic [15:0] r_frames;

    logic        w_accept;
    logic        w_start;
    logic        w_vbusy;
    logic        w_dbusy;
    logic [7:0]  w_vrem;
    logic [15:0] w_drem;
    logic [15:0] w_ddiv;
    logic [15:0] w_cap;
    logic signed [9:0] w_vsum;
    logic [6:0]  w_vout;
    logic [15:0] w_dly;

    assign o_in_ready = (r_state == F_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_start    = w_accept && (i_kind == K_SCHED);

    // timing divisor: ms * 48 + 1
    assign w_ddiv = ({6'd0, i_time_spread} << 5) + ({6'd0, i_time_spread} << 4) + 16'd1;

    hndq_urem #(.DW(8)) u_vrem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (i_random_velocity),
        .i_divisor  ({i_vel_spread, 1'b1}),
        .o_busy     (w_vbusy),
        .o_rem      (w_vrem)
    );

    hndq_urem #(.DW(16)) u_drem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (i_random_delay),
        .i_divisor  (w_ddiv),
        .o_busy     (w_dbusy),
        .o_rem      (w_drem)
    );

    assign w_vsum = $signed({3'd0, r_vel}) + $signed({2'd0, w_vrem})
                  - $signed({3'd0, i_vel_spread});

    always_comb begin
        if (i_vel_spread == '0) begin
            w_vout = r_vel;
        end else if (w_vsum < 10'sd1) begin
            w_vout = 7'd1;
        end else if (w_vsum > $signed({3'd0, VEL_MAX})) begin
            w_vout = VEL_MAX;
        end else begin
            w_vout = w_vsum[6:0];
        end
    end

    assign w_cap = r_row >> 1;
    assign w_dly = (w_drem < w_cap) ? w_drem : w_cap;

    always_comb begin
        o_q_cmd.kind   = r_kind;
        o_q_cmd.park   = (i_time_spread != '0);
        o_q_cmd.ev     = '{note: r_note, vel: w_vout, col: r_col, smp: r_smp};
        o_q_cmd.delay  = w_dly;
        o_q_cmd.frames = r_frames;
    end

    assign o_q_push = (r_state == F_PUSH) && !i_q_full;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    if (i_kind == K_SCHED) begin
                        n_state = F_CALC;
                    end else if (i_kind == K_ADV || i_kind == K_CANCEL) begin
                        n_state = F_PUSH;
                    end
                end
            end
            F_CALC: begin
                if (!w_vbusy && !w_dbusy) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind   <= i_kind;
            r_note   <= i_note_number;
            r_vel    <= i_note_velocity;
            r_col    <= i_column_id;
            r_smp    <= i_sample_slot;
            r_row    <= i_row_samples;
            r_frames <= i_frame_count;
        end
    end

endmodule

// ----- hw/rtl/hndq_queue.sv -----
// ----------------------------------------------------------------------------
// hndq_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module hndq_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hndq_pkg::t_cmd   i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output hndq_pkg::t_cmd   o_cmd
);
    import hndq_pkg::*;

    t_cmd       r_mem [QDEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ----- hw/rtl/hndq_back.sv -----
// ----------------------------------------------------------------------------
// hndq_back
// Slot table: parks notes, counts delays down and fires notes in slot order.
// ----------------------------------------------------------------------------
module hndq_back #(
    parameter int N = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  hndq_pkg::t_cmd   i_q_cmd,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output hndq_pkg::t_note  o_ev,
    output logic             o_last
);
    import hndq_pkg::*;

    localparam int IW = (N > 1) ? $clog2(N) : 1;

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_START = 2'd1;
    localparam logic [1:0] B_WALK  = 2'd2;
    localparam logic [1:0] B_FLUSH = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    t_cmd          r_cmd;
    logic [IW-1:0] r_idx;

    logic          r_act  [N];
    t_note         r_slot [N];
    logic [15:0]   r_dly  [N];

    logic          r_held_v;
    t_note         r_held;
    logic          r_o_valid;
    t_note         r_o_ev;
    logic          r_o_last;

    t_note         w_cur;
    logic          w_act_i;
    logic [16:0]   w_diff;
    logic          w_fire;
    logic          w_take;
    logic          w_last_i;

    logic          w_drop;
    logic [5:0]    w_drop_col;
    logic          w_wr;
    logic          w_dly_wr;
    logic          w_hold;
    t_note         w_hold_val;
    logic          w_emit;
    logic          w_emit_last;
    logic          w_idx_clr;
    logic          w_idx_inc;

    assign w_cur    = r_slot[r_idx];
    assign w_act_i  = r_act[r_idx];
    assign w_diff   = {1'b0, r_dly[r_idx]} - {1'b0, r_cmd.frames};
    assign w_fire   = w_diff[16] || (w_diff[15:0] == '0);
    assign w_take   = !r_o_valid || i_out_ready;
    assign w_last_i = (r_idx == IW'(N - 1));

    assign o_out_valid = r_o_valid;
    assign o_ev        = r_o_ev;
    assign o_last      = r_o_last;

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        w_drop      = 1'b0;
        w_drop_col  = r_cmd.ev.col;
        w_wr        = 1'b0;
        w_dly_wr    = 1'b0;
        w_hold      = 1'b0;
        w_hold_val  = r_cmd.ev;
        w_emit      = 1'b0;
        w_emit_last = 1'b0;
        w_idx_clr   = 1'b0;
        w_idx_inc   = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = B_START;
                end
            end
            B_START: begin
                w_idx_clr = 1'b1;
                case (r_cmd.kind)
                    K_SCHED: begin
                        w_drop = 1'b1;
                        if (r_cmd.park) begin
                            n_state = B_WALK;
                        end else begin
                            w_hold  = 1'b1;
                            n_state = B_FLUSH;
                        end
                    end
                    K_ADV: n_state = B_WALK;
                    K_CANCEL: begin
                        w_drop  = 1'b1;
                        n_state = B_IDLE;
                    end
                    default: n_state = B_IDLE;
                endcase
            end
            B_WALK: begin
                if (r_cmd.kind == K_SCHED) begin
                    // first free slot takes the note, a full table fires it
                    if (!w_act_i) begin
                        w_wr    = 1'b1;
                        n_state = B_IDLE;
                    end else if (w_last_i) begin
                        w_hold  = 1'b1;
                        n_state = B_FLUSH;
                    end else begin
                        w_idx_inc = 1'b1;
                    end
                end else if (w_act_i && w_fire) begin
                    // held result goes out once we know another one follows
                    if (!r_held_v || w_take) begin
                        w_emit     = r_held_v;
                        w_hold     = 1'b1;
                        w_hold_val = w_cur;
                        w_drop     = 1'b1;
                        w_drop_col = w_cur.col;
                        if (w_last_i) begin
                            n_state = B_FLUSH;
                        end else begin
                            w_idx_inc = 1'b1;
                        end
                    end
                end else begin
                    w_dly_wr = w_act_i;
                    if (w_last_i) begin
                        n_state = B_FLUSH;
                    end else begin
                        w_idx_inc = 1'b1;
                    end
                end
            end
            B_FLUSH: begin
                if (!r_held_v) begin
                    n_state = B_IDLE;
                end else if (w_take) begin
                    w_emit_last = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_held_v  <= 1'b0;
            r_o_valid <= 1'b0;
            for (int j = 0; j < N; j++) begin
                r_act[j] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (w_hold) begin
                r_held_v <= 1'b1;
            end else if (w_emit_last) begin
                r_held_v <= 1'b0;
            end
            if (w_emit || w_emit_last) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            for (int j = 0; j < N; j++) begin
                if (w_drop && r_slot[j].col == w_drop_col) begin
                    r_act[j] <= 1'b0;
                end
                if (w_wr && r_idx == IW'(j)) begin
                    r_act[j] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (w_idx_clr) begin
            r_idx <= '0;
        end else if (w_idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (w_wr) begin
            r_slot[r_idx] <= r_cmd.ev;
            r_dly[r_idx]  <= r_cmd.delay;
        end else if (w_dly_wr) begin
            r_dly[r_idx] <= w_diff[15:0];
        end
        if (w_hold) begin
            r_held <= w_hold_val;
        end
        if (w_emit || w_emit_last) begin
            r_o_ev   <= r_held;
            r_o_last <= w_emit_last;
        end
    end

`ifndef NO_ASSERTIONS
    a_held_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_v |-> (r_state == B_WALK || r_state == B_FLUSH))
        else $error("held result outside a walk");

    a_walk_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_WALK) |-> (r_cmd.kind == K_SCHED || r_cmd.kind == K_ADV))
        else $error("walk on a command that does not walk");

    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit_last |=> (r_o_valid && r_o_last && r_state == B_IDLE && !r_held_v))
        else $error("final result not presented");
`endif

endmodule
